// File: rtl/acpb_pkg.sv
package acpb_pkg;

  localparam int unsigned DefMaxStations = 256;
  localparam int unsigned InW   = 16;
  localparam int unsigned SumW  = 24;
  localparam int unsigned AccW  = 48;
  localparam int unsigned OutW  = 32;
  localparam int unsigned CntW  = 9;
  localparam int unsigned NComp = 8;
  localparam int unsigned QuoW  = 49;

  typedef struct packed {
    logic load;
    logic clear;
    logic div_start;
    logic out_load;
  } acpb_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } acpb_stat_t;

endpackage

// File: rtl/acpb_div.sv
module acpb_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [acpb_pkg::AccW-1:0]      dividend,
  input  logic [acpb_pkg::AccW-1:0]             divisor,
  output logic                                  busy,
  output logic                                  done,
  output logic signed [acpb_pkg::OutW-1:0]      quotient
);
  import acpb_pkg::*;

  localparam int unsigned StepW = $clog2(AccW + 1);

  logic [AccW-1:0]  rem;
  logic [AccW-1:0]  quo;
  logic [AccW-1:0]  dvs;
  logic             neg;
  logic [StepW-1:0] step;
  logic [AccW:0]    trial;
  logic [AccW-1:0]  mag;
  logic signed [AccW:0] sq;

  assign mag   = dividend[AccW-1] ? (~dividend + 1'b1) : dividend;
  assign trial = {rem[AccW-1:0], quo[AccW-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= mag;
        dvs  <= divisor;
        neg  <= dividend[AccW-1];
        step <= StepW'(AccW);
      end else if (busy) begin
        if (!trial[AccW]) begin
          rem <= trial[AccW-1:0];
          quo <= {quo[AccW-2:0], 1'b1};
        end else begin
          rem <= {rem[AccW-2:0], quo[AccW-1]};
          quo <= {quo[AccW-2:0], 1'b0};
        end
        step <= step - 1'b1;
        if (step == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sq = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_comb begin
    if (sq > $signed((AccW+1)'(32'sh7fffffff))) begin
      quotient = 32'sh7fffffff;
    end else if (sq < -$signed((AccW+1)'(33'sh080000000))) begin
      quotient = 32'sh80000000;
    end else begin
      quotient = sq[OutW-1:0];
    end
  end

endmodule

// File: rtl/acpb_datapath.sv
module acpb_datapath (
  input  logic                                   clk,
  input  acpb_pkg::acpb_cmd_t                    cmd,
  output acpb_pkg::acpb_stat_t                   stat,
  input  logic                                   rst,
  input  logic signed [acpb_pkg::InW-1:0]        q_in [acpb_pkg::NComp],
  input  logic [acpb_pkg::AccW-1:0]              baselines,
  output logic signed [acpb_pkg::OutW-1:0]       avg [acpb_pkg::NComp]
);
  import acpb_pkg::*;

  logic signed [SumW-1:0] esum [NComp];
  logic signed [AccW-1:0] acc  [NComp];
  logic signed [AccW-1:0] delta [NComp];
  logic [NComp-1:0] dbusy, ddone;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 2; c++) begin
        delta[2*(2*r+c)]   = '0;
        delta[2*(2*r+c)+1] = '0;
        for (int k = 0; k < 2; k++) begin
          delta[2*(2*r+c)] = delta[2*(2*r+c)]
            + AccW'(esum[2*(2*r+k)] * q_in[2*(2*c+k)])
            + AccW'(esum[2*(2*r+k)+1] * q_in[2*(2*c+k)+1]);
          delta[2*(2*r+c)+1] = delta[2*(2*r+c)+1]
            + AccW'(esum[2*(2*r+k)+1] * q_in[2*(2*c+k)])
            - AccW'(esum[2*(2*r+k)] * q_in[2*(2*c+k)+1]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NComp; j++) begin
      if (rst || cmd.clear) begin
        esum[j] <= '0;
        acc[j]  <= '0;
      end else if (cmd.load) begin
        esum[j] <= esum[j] + SumW'(q_in[j]);
        acc[j]  <= acc[j] + delta[j];
      end
    end
  end

  for (genvar g = 0; g < NComp; g++) begin : g_div
    logic signed [OutW-1:0] qv;
    acpb_div u_div (
      .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(acc[g]),
      .divisor(baselines), .busy(dbusy[g]), .done(ddone[g]), .quotient(qv)
    );
    always_ff @(posedge clk) begin
      if (cmd.out_load) begin
        avg[g] <= qv;
      end
    end
  end

  assign stat.div_busy = |dbusy;
  assign stat.div_done = ddone[0];

endmodule

// File: rtl/acpb_ctrl.sv
module acpb_ctrl #(
  parameter int unsigned MaxStations = acpb_pkg::DefMaxStations
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  logic [acpb_pkg::CntW-1:0]    stn_count,
  input  acpb_pkg::acpb_stat_t         stat,
  output acpb_pkg::acpb_cmd_t          cmd,
  output logic [acpb_pkg::AccW-1:0]    baselines
);
  import acpb_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxStations + 1);

  typedef enum logic [1:0] {ST_RUN, ST_START, ST_DIV, ST_OUT} state_t;

  state_t          state;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] n_eff;
  logic            last;
  logic [2*IdxW-1:0] prod;

  always_comb begin
    if (stn_count < CntW'(2)) begin
      n_eff = IdxW'(2);
    end else if (32'(stn_count) > MaxStations) begin
      n_eff = IdxW'(MaxStations);
    end else begin
      n_eff = IdxW'(stn_count);
    end
  end

  assign prod = n_eff * (n_eff - 1'b1);

  assign in_ready = (state == ST_RUN);
  assign cmd.load = in_valid && in_ready;
  assign last = (idx + 1'b1) >= n_eff;
  assign cmd.div_start = (state == ST_START);
  assign cmd.out_load = stat.div_done;
  assign cmd.clear = stat.div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      idx       <= '0;
      out_valid <= 1'b0;
      baselines <= '0;
    end else begin
      case (state)
        ST_RUN: begin
          if (cmd.load) begin
            idx <= idx + 1'b1;
            if (last) begin
              baselines <= AccW'(prod >> 1);
              state     <= ST_START;
            end
          end
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (stat.div_done) begin
            idx       <= '0;
            out_valid <= 1'b1;
            state     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst) stat.div_done |-> state == ST_DIV)
    else $error("divider finished outside divide state");
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |=> stat.div_busy)
    else $error("divider did not start");

endmodule

// File: rtl/average_cross_power_beam.sv
// Average cross-power beam: stream one 2x2 complex Jones matrix per station; after
// the configured station count of items one averaged matrix appears on the output.
// Items are taken back to back while in_ready is high. After the last item of a source a
// 48-step shift-subtract divide runs; the result and out_valid are registered when it
// finishes, and no input is taken until the result is accepted.
module average_cross_power_beam #(
  parameter int unsigned MaxStations = acpb_pkg::DefMaxStations
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [acpb_pkg::CntW-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [acpb_pkg::InW-1:0]     xx_re,
  input  logic signed [acpb_pkg::InW-1:0]     xx_im,
  input  logic signed [acpb_pkg::InW-1:0]     xy_re,
  input  logic signed [acpb_pkg::InW-1:0]     xy_im,
  input  logic signed [acpb_pkg::InW-1:0]     yx_re,
  input  logic signed [acpb_pkg::InW-1:0]     yx_im,
  input  logic signed [acpb_pkg::InW-1:0]     yy_re,
  input  logic signed [acpb_pkg::InW-1:0]     yy_im,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [acpb_pkg::OutW-1:0]    avg_xx_re,
  output logic signed [acpb_pkg::OutW-1:0]    avg_xx_im,
  output logic signed [acpb_pkg::OutW-1:0]    avg_xy_re,
  output logic signed [acpb_pkg::OutW-1:0]    avg_xy_im,
  output logic signed [acpb_pkg::OutW-1:0]    avg_yx_re,
  output logic signed [acpb_pkg::OutW-1:0]    avg_yx_im,
  output logic signed [acpb_pkg::OutW-1:0]    avg_yy_re,
  output logic signed [acpb_pkg::OutW-1:0]    avg_yy_im
);
  import acpb_pkg::*;

  logic [CntW-1:0]        stn_count;
  acpb_cmd_t              cmd;
  acpb_stat_t             stat;
  logic [AccW-1:0]        baselines;
  logic signed [InW-1:0]  q_in [NComp];
  logic signed [OutW-1:0] avg  [NComp];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stn_count <= CntW'(2);
    end else if (cfg_valid) begin
      stn_count <= cfg_data;
    end
  end

  assign q_in[0] = xx_re;
  assign q_in[1] = xx_im;
  assign q_in[2] = xy_re;
  assign q_in[3] = xy_im;
  assign q_in[4] = yx_re;
  assign q_in[5] = yx_im;
  assign q_in[6] = yy_re;
  assign q_in[7] = yy_im;

  acpb_ctrl #(.MaxStations(MaxStations)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stn_count(stn_count),
    .stat(stat), .cmd(cmd), .baselines(baselines)
  );

  acpb_datapath u_dp (
    .clk(clk), .cmd(cmd), .stat(stat), .rst(rst), .q_in(q_in),
    .baselines(baselines), .avg(avg)
  );

  assign avg_xx_re = avg[0];
  assign avg_xx_im = avg[1];
  assign avg_xy_re = avg[2];
  assign avg_xy_im = avg[3];
  assign avg_yx_re = avg[4];
  assign avg_yx_im = avg[5];
  assign avg_yy_re = avg[6];
  assign avg_yy_im = avg[7];

endmodule
